[design/iqd_pkg.sv]
// Shared types, constants and the CORDIC angle table for the I/Q AM/FM demodulator.
package iqd_pkg;

	localparam int DEF_SAMPLE_WIDTH  = 16;
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int ATAN_LEN          = 24;
	localparam int ANGLE_W           = 32;
	localparam int PHASE_W           = 16;
	localparam int OUT_W             = 17;
	localparam int OUT_TDATA_W       = ((OUT_W + 7) / 8) * 8;
	// x/y headroom over the sample width: 16 bits of scale, pre-rotation, CORDIC gain, sign
	localparam int XY_GUARD          = 19;

	typedef enum logic {
		MODE_AM = 1'b0,
		MODE_FM = 1'b1
	} demod_mode_t;

	// per-item control that rides along the cell chain
	typedef struct packed {
		logic valid;
		logic first;
		logic zero;
	} ctl_t;

	// atan(2^-k) in units of pi/2^31
	function automatic logic [ANGLE_W-1:0] atan_angle(input int k);
		logic [ANGLE_W-1:0] a;
		case (k)
			0:       a = 32'h2000_0000;
			1:       a = 32'h12E4_051E;
			2:       a = 32'h09FB_385B;
			3:       a = 32'h0511_11D4;
			4:       a = 32'h028B_0D43;
			5:       a = 32'h0145_D7E1;
			6:       a = 32'h00A2_F61E;
			7:       a = 32'h0051_7C55;
			8:       a = 32'h0028_BE53;
			9:       a = 32'h0014_5F2F;
			10:      a = 32'h000A_2F98;
			11:      a = 32'h0005_17CC;
			12:      a = 32'h0002_8BE6;
			13:      a = 32'h0001_45F3;
			14:      a = 32'h0000_A2FA;
			15:      a = 32'h0000_517D;
			16:      a = 32'h0000_28BE;
			17:      a = 32'h0000_145F;
			18:      a = 32'h0000_0A30;
			19:      a = 32'h0000_0518;
			20:      a = 32'h0000_028C;
			21:      a = 32'h0000_0146;
			22:      a = 32'h0000_00A3;
			23:      a = 32'h0000_0051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[design/iqd_front.sv]
// Front end: unpack sample, pre-rotate by pi, square magnitudes, sum of squares.
module iqd_front #(
	parameter int SAMPLE_WIDTH = iqd_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic signed [SAMPLE_WIDTH-1:0]        in_i,
	input  logic signed [SAMPLE_WIDTH-1:0]        in_q,
	input  logic                                  in_first,
	output iqd_pkg::ctl_t                         ctl_out,
	output logic signed [SAMPLE_WIDTH+iqd_pkg::XY_GUARD-1:0] x_out,
	output logic signed [SAMPLE_WIDTH+iqd_pkg::XY_GUARD-1:0] y_out,
	output logic [iqd_pkg::ANGLE_W-1:0]           z_out,
	output logic [2*SAMPLE_WIDTH-1:0]             sum_out
);

	localparam int CW  = SAMPLE_WIDTH + iqd_pkg::XY_GUARD;
	localparam int SQW = 2 * SAMPLE_WIDTH;

	logic signed [CW-1:0]          ie, qe, x0, y0;
	logic [iqd_pkg::ANGLE_W-1:0]   z0;
	logic [SAMPLE_WIDTH-1:0]       ai, aq;
	iqd_pkg::ctl_t                 ctl0;

	iqd_pkg::ctl_t                 ctl_s1, ctl_s2;
	logic signed [CW-1:0]          x_s1, y_s1, x_s2, y_s2;
	logic [iqd_pkg::ANGLE_W-1:0]   z_s1, z_s2;
	logic [SQW-1:0]                ii_s1, qq_s1, sum_s2;

	always_comb begin
		ie = CW'(in_i);
		qe = CW'(in_q);
		if (in_i[SAMPLE_WIDTH-1]) begin
			x0 = -ie;
			y0 = -qe;
			z0 = {1'b1, {(iqd_pkg::ANGLE_W-1){1'b0}}};
		end else begin
			x0 = ie;
			y0 = qe;
			z0 = '0;
		end
		// magnitudes as unsigned; the most negative code maps to 2^(W-1)
		ai = in_i[SAMPLE_WIDTH-1] ? (~in_i + 1'b1) : in_i;
		aq = in_q[SAMPLE_WIDTH-1] ? (~in_q + 1'b1) : in_q;
		ctl0.valid = in_valid;
		ctl0.first = in_first;
		ctl0.zero  = (in_i == '0) && (in_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl0;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x0 <<< 16;
			y_s1   <= y0 <<< 16;
			z_s1   <= z0;
			ii_s1  <= SQW'(ai) * SQW'(ai);
			qq_s1  <= SQW'(aq) * SQW'(aq);
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;
			sum_s2 <= ii_s1 + qq_s1;
		end
	end

	assign ctl_out = ctl_s2;
	assign x_out   = x_s2;
	assign y_out   = y_s2;
	assign z_out   = z_s2;
	assign sum_out = sum_s2;

endmodule

[design/iqd_cell.sv]
// One chain cell: a CORDIC vectoring micro-rotation and one square-root digit step, each while K is in range.
module iqd_cell #(
	parameter int SAMPLE_WIDTH  = iqd_pkg::DEF_SAMPLE_WIDTH,
	parameter int CORDIC_STAGES = iqd_pkg::DEF_CORDIC_STAGES,
	parameter int K             = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  iqd_pkg::ctl_t                         ctl_in,
	input  logic signed [SAMPLE_WIDTH+iqd_pkg::XY_GUARD-1:0] x_in,
	input  logic signed [SAMPLE_WIDTH+iqd_pkg::XY_GUARD-1:0] y_in,
	input  logic [iqd_pkg::ANGLE_W-1:0]           z_in,
	input  logic [2*SAMPLE_WIDTH-1:0]             rem_in,
	input  logic [2*SAMPLE_WIDTH-1:0]             res_in,
	output iqd_pkg::ctl_t                         ctl_out,
	output logic signed [SAMPLE_WIDTH+iqd_pkg::XY_GUARD-1:0] x_out,
	output logic signed [SAMPLE_WIDTH+iqd_pkg::XY_GUARD-1:0] y_out,
	output logic [iqd_pkg::ANGLE_W-1:0]           z_out,
	output logic [2*SAMPLE_WIDTH-1:0]             rem_out,
	output logic [2*SAMPLE_WIDTH-1:0]             res_out
);

	localparam int  CW        = SAMPLE_WIDTH + iqd_pkg::XY_GUARD;
	localparam int  SQW       = 2 * SAMPLE_WIDTH;
	localparam bit  CORDIC_ON = (K < CORDIC_STAGES) && (K < iqd_pkg::ATAN_LEN);
	localparam bit  SQRT_ON   = (K < SAMPLE_WIDTH);
	localparam int  BIT_POS   = SQRT_ON ? 2 * (SAMPLE_WIDTH - 1 - K) : 0;
	localparam logic [iqd_pkg::ANGLE_W-1:0] ANG = iqd_pkg::atan_angle(K);
	localparam logic [SQW-1:0] BIT = SQW'(1) << BIT_POS;

	logic signed [CW-1:0]        dx, dy, x_n, y_n;
	logic [iqd_pkg::ANGLE_W-1:0] z_n;
	logic [SQW-1:0]              trial, rem_n, res_n;

	iqd_pkg::ctl_t               ctl_q;
	logic signed [CW-1:0]        x_q, y_q;
	logic [iqd_pkg::ANGLE_W-1:0] z_q;
	logic [SQW-1:0]              rem_q, res_q;

	always_comb begin
		dx = x_in >>> K;
		dy = y_in >>> K;
		x_n = x_in;
		y_n = y_in;
		z_n = z_in;
		if (CORDIC_ON) begin
			if (!y_in[CW-1]) begin
				x_n = x_in + dy;
				y_n = y_in - dx;
				z_n = z_in + ANG;
			end else begin
				x_n = x_in - dy;
				y_n = y_in + dx;
				z_n = z_in - ANG;
			end
		end
	end

	always_comb begin
		trial = res_in + BIT;
		rem_n = rem_in;
		res_n = res_in;
		if (SQRT_ON) begin
			if (rem_in >= trial) begin
				rem_n = rem_in - trial;
				res_n = (res_in >> 1) + BIT;
			end else begin
				res_n = res_in >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q   <= x_n;
			y_q   <= y_n;
			z_q   <= z_n;
			rem_q <= rem_n;
			res_q <= res_n;
		end
	end

	assign ctl_out = ctl_q;
	assign x_out   = x_q;
	assign y_out   = y_q;
	assign z_out   = z_q;
	assign rem_out = rem_q;
	assign res_out = res_q;

endmodule

[design/iq_am_fm_demodulator.sv]
// Top level of the I/Q AM/FM demodulator: front end, cell chain, result stage.
//
//  channel  | dir | handshake          | payload (lowest bit up)
//  ---------+-----+--------------------+------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tdata: sample_i, sample_q; tuser: first_sample
//  m_*      | out | m_tvalid/m_tready  | tdata: demod_value (17b, signed in FM), zero fill
//  cfg_*    | in  | cfg_wr_en          | cfg_wr_data: demod_mode
//
// Throughput is one transaction per clock while the output is not stalled. The pipe runs
// through two front-end stages (squares, then sum), one cell per CORDIC rotation or root
// digit, and the output register, which also forms the phase difference and rounding.
// The whole pipe advances on one enable: it moves whenever the output register is empty
// or being taken, so s_tready drops only while a result waits and m_tready is low.
// Reset clears demod_mode, the stored phase and all valid bits; no clearing pass.
module iq_am_fm_demodulator #(
	parameter int SAMPLE_WIDTH  = iqd_pkg::DEF_SAMPLE_WIDTH,
	parameter int CORDIC_STAGES = iqd_pkg::DEF_CORDIC_STAGES
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            s_tvalid,
	output logic                                            s_tready,
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]             s_tdata,  // sample_i, sample_q
	input  logic                                            s_tuser,  // first_sample
	output logic                                            m_tvalid,
	input  logic                                            m_tready,
	output logic [iqd_pkg::OUT_TDATA_W-1:0]                 m_tdata,  // demod_value
	input  logic                                            cfg_wr_en,
	input  logic                                            cfg_wr_data
);

	localparam int CW  = SAMPLE_WIDTH + iqd_pkg::XY_GUARD;
	localparam int SQW = 2 * SAMPLE_WIDTH;
	localparam int N   = (CORDIC_STAGES > SAMPLE_WIDTH) ? CORDIC_STAGES : SAMPLE_WIDTH;

	// pipe enable: everything moves together
	logic adv;

	iqd_pkg::demod_mode_t mode_q;

	// chain taps: index 0 is the front-end output, index N the last cell
	iqd_pkg::ctl_t               ctl_c [0:N];
	logic signed [CW-1:0]        x_c   [0:N];
	logic signed [CW-1:0]        y_c   [0:N];
	logic [iqd_pkg::ANGLE_W-1:0] z_c   [0:N];
	logic [SQW-1:0]              rem_c [0:N];
	logic [SQW-1:0]              res_c [0:N];

	iqd_pkg::ctl_t               last;
	logic                        out_load;
	logic                        rnd_up;
	logic [SAMPLE_WIDTH:0]       mag;
	logic [iqd_pkg::ANGLE_W-1:0] z_rnd;
	logic signed [iqd_pkg::PHASE_W-1:0] phase;
	logic signed [iqd_pkg::OUT_W-1:0]   diff;
	logic [iqd_pkg::OUT_W-1:0]   result;

	logic signed [iqd_pkg::PHASE_W-1:0] prev_phase_q;
	logic                        out_valid_q;
	logic [iqd_pkg::OUT_W-1:0]   out_data_q;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	// config register; to be written only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= iqd_pkg::MODE_AM;
		end else if (cfg_wr_en) begin
			mode_q <= iqd_pkg::demod_mode_t'(cfg_wr_data);
		end
	end

	iqd_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (s_tvalid),
		.in_i     (s_tdata[SAMPLE_WIDTH-1:0]),
		.in_q     (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
		.in_first (s_tuser),
		.ctl_out  (ctl_c[0]),
		.x_out    (x_c[0]),
		.y_out    (y_c[0]),
		.z_out    (z_c[0]),
		.sum_out  (rem_c[0])
	);

	// root accumulator starts empty
	assign res_c[0] = '0;

	// one cell per rotation / root digit
	for (genvar k = 0; k < N; k++) begin : g_cell
		iqd_cell #(
			.SAMPLE_WIDTH  (SAMPLE_WIDTH),
			.CORDIC_STAGES (CORDIC_STAGES),
			.K             (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.ctl_in  (ctl_c[k]),
			.x_in    (x_c[k]),
			.y_in    (y_c[k]),
			.z_in    (z_c[k]),
			.rem_in  (rem_c[k]),
			.res_in  (res_c[k]),
			.ctl_out (ctl_c[k+1]),
			.x_out   (x_c[k+1]),
			.y_out   (y_c[k+1]),
			.z_out   (z_c[k+1]),
			.rem_out (rem_c[k+1]),
			.res_out (res_c[k+1])
		);
	end

	assign last     = ctl_c[N];
	assign out_load = adv && last.valid;

	// result stage: round root to nearest, round angle to 16 bits, difference in FM
	always_comb begin
		// s - r^2 > r  <=>  remainder > root
		rnd_up = rem_c[N] > res_c[N];
		mag    = (SAMPLE_WIDTH+1)'(res_c[N][SAMPLE_WIDTH-1:0]) + (SAMPLE_WIDTH+1)'(rnd_up);
		z_rnd  = z_c[N] + 32'h0000_8000;
		phase  = last.zero ? '0 : $signed(z_rnd[iqd_pkg::ANGLE_W-1:iqd_pkg::ANGLE_W-16]);
		diff   = iqd_pkg::OUT_W'(phase) - iqd_pkg::OUT_W'(prev_phase_q);
		case (mode_q)
			iqd_pkg::MODE_FM: result = last.first ? '0 : diff;
			iqd_pkg::MODE_AM: result = iqd_pkg::OUT_W'(mag);
			default:          result = iqd_pkg::OUT_W'(mag);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			prev_phase_q <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= last.valid;
			end
			// phase is kept in either mode
			if (out_load) begin
				prev_phase_q <= phase;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(iqd_pkg::OUT_TDATA_W-iqd_pkg::OUT_W){1'b0}}, out_data_q};

	// a new result only ever comes from a valid item at the chain end
	a_rise_from_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(last.valid))
		else $error("output valid without an item at the chain end");

	// stored phase moves only with a transaction into the output register
	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!out_load |=> $stable(prev_phase_q))
		else $error("stored phase changed without a result");

	// first sample of a signal in FM mode gives zero
	a_fm_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && mode_q == iqd_pkg::MODE_FM && last.first) |=> (out_data_q == '0))
		else $error("first FM sample not zero");

	// a stalled pipe keeps its items in place
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(last) && $stable(ctl_c[0]))
		else $error("chain moved during a stall");

endmodule
